### hdl/shared_segment_refcount_table_defines.svh
// assertion macros for the shared segment reference count table
`ifndef SHARED_SEGMENT_REFCOUNT_TABLE_DEFINES_SVH
`define SHARED_SEGMENT_REFCOUNT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define SSRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SSRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SSRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/ssrt_pkg.sv
// shared types and constants of the shared segment reference count table
package ssrt_pkg;

    localparam int KEY_W      = 31;
    localparam int PID_W      = 6;
    localparam int STATUS_W   = 3;
    localparam int GSLOT_W    = 4;
    localparam int USERS_W    = 7;
    localparam int GUSED_W    = 5;
    localparam int PUSED_W    = 4;
    localparam int SCAN_IDX_W = 8;
    localparam int SCAN_CNT_W = 9;

    localparam logic [USERS_W-1:0] USERS_MAX = 7'd127;

    typedef enum logic [0:0] {
        CMD_ATTACH = 1'b0,
        CMD_DETACH = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_HELD       = 3'd1,
        ST_PROC_FULL  = 3'd2,
        ST_GLOB_FULL  = 3'd3,
        ST_NOT_HELD   = 3'd4,
        ST_NOT_GLOBAL = 3'd5
    } t_status;

    typedef struct packed {
        logic                  hit;
        logic [SCAN_IDX_W-1:0] hit_idx;
        logic                  has_empty;
        logic [SCAN_IDX_W-1:0] empty_idx;
        logic [SCAN_CNT_W-1:0] used;
    } t_scan;

endpackage

### hdl/ssrt_ram.sv
// generic single write port memory with registered read
module ssrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ssrt_scan.sv
// scan accumulator: first key match, last empty entry and occupied count
module ssrt_scan
    import ssrt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clr,
    input  logic                  i_vld,
    input  logic [SCAN_IDX_W-1:0] i_idx,
    input  logic [KEY_W-1:0]      i_key,
    input  logic [KEY_W-1:0]      i_data,
    output logic                  o_first,
    output t_scan                 o_res
);

    t_scan r_res;
    t_scan n_res;
    logic  match;
    logic  empty;

    assign match   = (i_data == i_key) && (i_key != '0);
    assign empty   = (i_data == '0);
    assign o_first = i_vld && match && !r_res.hit;

    always_comb begin
        n_res = r_res;
        if (i_clr) begin
            n_res = '0;
        end else if (i_vld) begin
            if (match && !r_res.hit) begin
                n_res.hit     = 1'b1;
                n_res.hit_idx = i_idx;
            end
            if (empty) begin
                n_res.has_empty = 1'b1;
                n_res.empty_idx = i_idx;
            end else begin
                n_res.used = r_res.used + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### hdl/shared_segment_refcount_table.sv
// top level of the shared segment reference count table
//
// channel   direction  handshake               payload
// request   in         start high, busy low    i_cmd, i_process_id, i_signature
// result    out        o_done, one cycle       o_status, o_global_slot, o_users_after,
//                                               o_global_used, o_process_used
//
// a transaction steps through S_MOD, which folds i_process_id into range by subtracting
// PROCESSES, then S_PSCAN and S_GSCAN, the slot-by-slot read of the process and global
// memories, and S_UPD; busy stays high until it is through
// after reset the memories are cleared one entry a cycle until every entry of both is
// zero, with busy high
// the result strobe cannot be held off; the next request is taken during the strobe cycle
`include "shared_segment_refcount_table_defines.svh"

module shared_segment_refcount_table
    import ssrt_pkg::*;
#(
    parameter int GLOBAL_ENTRIES    = 16,
    parameter int SLOTS_PER_PROCESS = 8,
    parameter int PROCESSES         = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cmd,
    input  logic [PID_W-1:0]    i_process_id,
    input  logic [KEY_W-1:0]    i_signature,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [GSLOT_W-1:0]  o_global_slot,
    output logic [USERS_W-1:0]  o_users_after,
    output logic [GUSED_W-1:0]  o_global_used,
    output logic [PUSED_W-1:0]  o_process_used
);

    localparam int PS_N   = PROCESSES * SLOTS_PER_PROCESS;
    localparam int PAW    = (PS_N > 1) ? $clog2(PS_N) : 1;
    localparam int GAW    = (GLOBAL_ENTRIES > 1) ? $clog2(GLOBAL_ENTRIES) : 1;
    localparam int GDW    = KEY_W + USERS_W;
    localparam int SCAN_N = (SLOTS_PER_PROCESS > GLOBAL_ENTRIES) ? SLOTS_PER_PROCESS
                                                                  : GLOBAL_ENTRIES;
    localparam int CW     = $clog2(SCAN_N + 1);
    localparam int CLR_N  = (PS_N > GLOBAL_ENTRIES) ? PS_N : GLOBAL_ENTRIES;
    localparam int CLW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PSCAN,
        S_GSCAN,
        S_UPD
    } t_state;

    t_state                r_state, n_state;
    logic [CLW-1:0]        r_clr, n_clr;
    logic [CW-1:0]         r_cnt, n_cnt;
    t_cmd                  r_cmd, n_cmd;
    logic [PID_W-1:0]      r_pid, n_pid;
    logic [KEY_W-1:0]      r_key, n_key;
    logic                  r_prv, n_prv;
    logic                  r_grv, n_grv;
    logic [SCAN_IDX_W-1:0] r_ridx, n_ridx;
    logic [USERS_W-1:0]    r_guser, n_guser;
    logic                  r_done, n_done;
    t_status               r_status, n_status;
    logic [GSLOT_W-1:0]    r_gslot, n_gslot;
    logic [USERS_W-1:0]    r_users, n_users;
    logic [GUSED_W-1:0]    r_gused, n_gused;
    logic [PUSED_W-1:0]    r_pused, n_pused;

    logic                  p_we;
    logic [PAW-1:0]        p_waddr;
    logic [KEY_W-1:0]      p_wdata;
    logic [PAW-1:0]        p_raddr;
    logic [KEY_W-1:0]      p_rdata;
    logic                  g_we;
    logic [GAW-1:0]        g_waddr;
    logic [GDW-1:0]        g_wdata;
    logic [GAW-1:0]        g_raddr;
    logic [GDW-1:0]        g_rdata;

    t_scan                 p_res;
    t_scan                 g_res;
    logic                  p_first;
    logic                  g_first;
    logic                  scan_clr;
    logic [PAW-1:0]        base;

    t_status               u_status;
    logic [GAW-1:0]        u_gsel;
    logic [USERS_W-1:0]    u_users;
    logic                  u_gwr;
    logic [GDW-1:0]        u_gdata;
    logic                  u_pwr;
    logic [SCAN_IDX_W-1:0] u_poff;
    logic [KEY_W-1:0]      u_pdata;
    logic [SCAN_CNT_W-1:0] u_gused;
    logic [SCAN_CNT_W-1:0] u_pused;
    logic [USERS_W-1:0]    users_inc;
    logic [USERS_W-1:0]    users_dec;

    ssrt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (PS_N)
    ) u_proc_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    ssrt_ram #(
        .WIDTH (GDW),
        .DEPTH (GLOBAL_ENTRIES)
    ) u_glob_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    ssrt_scan u_proc_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (scan_clr),
        .i_vld   (r_prv),
        .i_idx   (r_ridx),
        .i_key   (r_key),
        .i_data  (p_rdata),
        .o_first (p_first),
        .o_res   (p_res)
    );

    ssrt_scan u_glob_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (scan_clr),
        .i_vld   (r_grv),
        .i_idx   (r_ridx),
        .i_key   (r_key),
        .i_data  (g_rdata[GDW-1 -: KEY_W]),
        .o_first (g_first),
        .o_res   (g_res)
    );

    assign busy     = (r_state != S_IDLE);
    assign scan_clr = (r_state == S_IDLE) && start;
    assign base     = PAW'(int'(r_pid) * SLOTS_PER_PROCESS);

    assign users_inc = (r_guser < USERS_MAX) ? r_guser + 1'b1 : r_guser;
    assign users_dec = (r_guser != '0) ? r_guser - 1'b1 : '0;

    // update decision from both scans
    always_comb begin
        u_status = ST_OK;
        u_gsel   = '0;
        u_users  = '0;
        u_gwr    = 1'b0;
        u_gdata  = '0;
        u_pwr    = 1'b0;
        u_poff   = '0;
        u_pdata  = '0;
        u_gused  = g_res.used;
        u_pused  = p_res.used;
        if (r_cmd == CMD_ATTACH) begin
            if ((r_key == '0) || p_res.hit) begin
                u_status = ST_HELD;
            end else if (!p_res.has_empty) begin
                u_status = ST_PROC_FULL;
            end else if (g_res.hit) begin
                u_gsel  = g_res.hit_idx[GAW-1:0];
                u_users = users_inc;
                u_gwr   = 1'b1;
                u_gdata = {r_key, users_inc};
                u_pwr   = 1'b1;
                u_poff  = p_res.empty_idx;
                u_pdata = r_key;
                u_pused = p_res.used + 1'b1;
            end else if (g_res.has_empty) begin
                u_gsel  = g_res.empty_idx[GAW-1:0];
                u_users = USERS_W'(1);
                u_gwr   = 1'b1;
                u_gdata = {r_key, USERS_W'(1)};
                u_pwr   = 1'b1;
                u_poff  = p_res.empty_idx;
                u_pdata = r_key;
                u_pused = p_res.used + 1'b1;
                u_gused = g_res.used + 1'b1;
            end else begin
                u_status = ST_GLOB_FULL;
            end
        end else begin
            if (!p_res.hit) begin
                u_status = ST_NOT_HELD;
            end else if (!g_res.hit) begin
                u_status = ST_NOT_GLOBAL;
            end else begin
                u_gsel  = g_res.hit_idx[GAW-1:0];
                u_users = users_dec;
                u_gwr   = 1'b1;
                u_gdata = (users_dec == '0) ? '0 : {r_key, users_dec};
                u_pwr   = 1'b1;
                u_poff  = p_res.hit_idx;
                u_pdata = '0;
                u_pused = p_res.used - 1'b1;
                if (users_dec == '0) begin
                    u_gused = g_res.used - 1'b1;
                end
            end
        end
    end

    // memory ports
    always_comb begin
        p_raddr = base + PAW'(r_cnt);
        g_raddr = GAW'(r_cnt);
        p_we    = 1'b0;
        p_waddr = base + PAW'(u_poff);
        p_wdata = u_pdata;
        g_we    = 1'b0;
        g_waddr = u_gsel;
        g_wdata = u_gdata;
        case (r_state)
            S_CLEAR: begin
                p_we    = (int'(r_clr) < PS_N);
                p_waddr = r_clr[PAW-1:0];
                p_wdata = '0;
                g_we    = (int'(r_clr) < GLOBAL_ENTRIES);
                g_waddr = r_clr[GAW-1:0];
                g_wdata = '0;
            end
            S_UPD: begin
                p_we = u_pwr;
                g_we = u_gwr;
            end
            default: begin
                p_we = 1'b0;
                g_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_cnt    = r_cnt;
        n_cmd    = r_cmd;
        n_pid    = r_pid;
        n_key    = r_key;
        n_prv    = 1'b0;
        n_grv    = 1'b0;
        n_ridx   = SCAN_IDX_W'(r_cnt);
        n_guser  = g_first ? g_rdata[USERS_W-1:0] : r_guser;
        n_done   = 1'b0;
        n_status = r_status;
        n_gslot  = r_gslot;
        n_users  = r_users;
        n_gused  = r_gused;
        n_pused  = r_pused;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == CLW'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_pid   = i_process_id;
                    n_key   = i_signature;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (int'(r_pid) >= PROCESSES) begin
                    n_pid = r_pid - PID_W'(PROCESSES);
                end else begin
                    n_cnt   = '0;
                    n_state = S_PSCAN;
                end
            end
            S_PSCAN: begin
                if (r_cnt == CW'(SLOTS_PER_PROCESS)) begin
                    n_cnt   = '0;
                    n_state = S_GSCAN;
                end else begin
                    n_prv = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_GSCAN: begin
                if (r_cnt == CW'(GLOBAL_ENTRIES)) begin
                    n_state = S_UPD;
                end else begin
                    n_grv = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UPD: begin
                n_done   = 1'b1;
                n_status = u_status;
                n_gslot  = GSLOT_W'(u_gsel);
                n_users  = u_users;
                n_gused  = GUSED_W'(u_gused);
                n_pused  = PUSED_W'(u_pused);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_prv   <= 1'b0;
            r_grv   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_prv   <= n_prv;
            r_grv   <= n_grv;
            r_done  <= n_done;
        end
        r_cnt    <= n_cnt;
        r_cmd    <= n_cmd;
        r_pid    <= n_pid;
        r_key    <= n_key;
        r_ridx   <= n_ridx;
        r_guser  <= n_guser;
        r_status <= n_status;
        r_gslot  <= n_gslot;
        r_users  <= n_users;
        r_gused  <= n_gused;
        r_pused  <= n_pused;
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_global_slot  = r_gslot;
    assign o_users_after  = r_users;
    assign o_global_used  = r_gused;
    assign o_process_used = r_pused;

    // checks
    `SSRT_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe held two cycles")
    `SSRT_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !p_we && !g_we, "memory write while idle")
    `SSRT_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_done && (o_status != ST_OK), (o_global_slot == '0) && (o_users_after == '0), "failed transaction reports a slot")
    `SSRT_ASSERT_IMP(a_attach_users, i_clk, i_rst_n, o_done && (o_status == ST_OK) && (r_cmd == CMD_ATTACH), o_users_after != '0, "attach left zero users")
    `SSRT_ASSERT_IMP(a_proc_hit_in_scan, i_clk, i_rst_n, p_first, (r_state == S_PSCAN) || (r_state == S_GSCAN), "process hit outside the slot scan")

endmodule

### sim/shared_segment_refcount_table_test.sv
// testbench of the shared segment reference count table: scoreboard class, drivers and checks
`timescale 1ns / 1ps

import ssrt_pkg::*;

localparam int NUM_ENTRIES = 16;
localparam int NUM_SLOTS   = 8;
localparam int NUM_PROCS   = 64;

typedef struct packed {
    t_status              status;
    logic [GSLOT_W-1:0]   slot;
    logic [USERS_W-1:0]   users;
    logic [GUSED_W-1:0]   gused;
    logic [PUSED_W-1:0]   pused;
} seg_result_t;

class refcount_scoreboard;
    bit [KEY_W-1:0]   glob_key[NUM_ENTRIES];
    bit [USERS_W-1:0] glob_users[NUM_ENTRIES];
    bit [KEY_W-1:0]   proc_key[NUM_PROCS][NUM_SLOTS];
    seg_result_t      pending_results[$];
    int               mismatches;
    int               checked;
    int               status_seen[8];

    task report_mismatch(string msg);
        if (mismatches < 40) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function void apply_request(t_cmd cmd, logic [PID_W-1:0] pid, logic [KEY_W-1:0] key);
        seg_result_t r;
        int held;
        int free_slot;
        int hit;
        int empty_idx;
        int own;
        r = '0;
        r.status = ST_OK;
        held = 0;
        free_slot = -1;
        hit = -1;
        empty_idx = -1;
        own = -1;
        if (cmd == CMD_ATTACH) begin
            if (key == '0) begin
                r.status = ST_HELD;
            end else begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (proc_key[pid][i] == key) begin
                        held = 1;
                        break;
                    end
                    if (proc_key[pid][i] == '0) free_slot = i;
                end
                if (held != 0) begin
                    r.status = ST_HELD;
                end else if (free_slot < 0) begin
                    r.status = ST_PROC_FULL;
                end else begin
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                        if (glob_key[i] == key) begin
                            hit = i;
                            break;
                        end
                        if (glob_key[i] == '0) empty_idx = i;
                    end
                    if (hit >= 0) begin
                        if (glob_users[hit] < USERS_MAX) glob_users[hit]++;
                        proc_key[pid][free_slot] = key;
                        r.slot = GSLOT_W'(hit);
                        r.users = glob_users[hit];
                    end else if (empty_idx >= 0) begin
                        glob_key[empty_idx] = key;
                        glob_users[empty_idx] = 1;
                        proc_key[pid][free_slot] = key;
                        r.slot = GSLOT_W'(empty_idx);
                        r.users = 1;
                    end else begin
                        r.status = ST_GLOB_FULL;
                    end
                end
            end
        end else begin
            if (key != '0) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (proc_key[pid][i] == key) begin
                        own = i;
                        break;
                    end
                end
            end
            if (own < 0) begin
                r.status = ST_NOT_HELD;
            end else begin
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (glob_key[i] == key) begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0) begin
                    r.status = ST_NOT_GLOBAL;
                end else begin
                    if (glob_users[hit] != 0) glob_users[hit]--;
                    proc_key[pid][own] = '0;
                    if (glob_users[hit] == 0) glob_key[hit] = '0;
                    r.slot = GSLOT_W'(hit);
                    r.users = glob_users[hit];
                end
            end
        end
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (glob_key[i] != '0) r.gused++;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (proc_key[pid][i] != '0) r.pused++;
        end
        pending_results.push_back(r);
    endfunction

    task check_result(logic [STATUS_W-1:0] status, logic [GSLOT_W-1:0] slot,
                      logic [USERS_W-1:0] users, logic [GUSED_W-1:0] gused,
                      logic [PUSED_W-1:0] pused);
        seg_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with no transaction pending, status %0d", status));
            return;
        end
        want = pending_results.pop_front();
        checked++;
        status_seen[want.status]++;
        if (status !== want.status)
            report_mismatch($sformatf("result %0d status got %0d want %0d",
                                      checked, status, want.status));
        if (slot !== want.slot)
            report_mismatch($sformatf("result %0d global_slot got %0d want %0d",
                                      checked, slot, want.slot));
        if (users !== want.users)
            report_mismatch($sformatf("result %0d users_after got %0d want %0d",
                                      checked, users, want.users));
        if (gused !== want.gused)
            report_mismatch($sformatf("result %0d global_used got %0d want %0d",
                                      checked, gused, want.gused));
        if (pused !== want.pused)
            report_mismatch($sformatf("result %0d process_used got %0d want %0d",
                                      checked, pused, want.pused));
    endtask
endclass

module shared_segment_refcount_table_test;

    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 600000;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_cmd = CMD_ATTACH;
    logic [PID_W-1:0]    i_process_id = '0;
    logic [KEY_W-1:0]    i_signature = '0;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [GSLOT_W-1:0]  o_global_slot;
    logic [USERS_W-1:0]  o_users_after;
    logic [GUSED_W-1:0]  o_global_used;
    logic [PUSED_W-1:0]  o_process_used;

    refcount_scoreboard sb = new();
    int                 sent = 0;
    int                 cycle_count = 0;
    logic [KEY_W-1:0]   key_pool[20];
    logic [PID_W-1:0]   hot_pid[4];

    shared_segment_refcount_table #(
        .GLOBAL_ENTRIES    (NUM_ENTRIES),
        .SLOTS_PER_PROCESS (NUM_SLOTS),
        .PROCESSES         (NUM_PROCS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_process_id   (i_process_id),
        .i_signature    (i_signature),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_global_slot  (o_global_slot),
        .o_users_after  (o_users_after),
        .o_global_used  (o_global_used),
        .o_process_used (o_process_used)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            sb.check_result(o_status, o_global_slot, o_users_after, o_global_used,
                            o_process_used);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic issue_request(t_cmd cmd, logic [PID_W-1:0] pid, logic [KEY_W-1:0] key);
        start <= 1'b1;
        i_cmd <= cmd;
        i_process_id <= pid;
        i_signature <= key;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.apply_request(cmd, pid, key);
        sent++;
    endtask

    task automatic idle_gap(bit quiet);
        int n;
        int roll;
        n = 0;
        roll = $urandom_range(0, 99);
        if (!quiet && roll >= 65) begin
            n = (roll < 95) ? $urandom_range(1, 8) : $urandom_range(9, 60);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    initial begin
        int               random_count;
        int               directed_count;
        int               phase;
        int               phase_len;
        int               attach_pct;
        int               roll;
        int               first;
        bit               quiet;
        t_cmd             cmd;
        logic [PID_W-1:0] pid;
        logic [KEY_W-1:0] key;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero key, unheld detach, join, release and both full cases
        issue_request(CMD_ATTACH, 6'd0, '0);
        issue_request(CMD_DETACH, 6'd0, '0);
        issue_request(CMD_DETACH, 6'd63, 31'h7FFF_FFFF);
        issue_request(CMD_ATTACH, 6'd63, 31'h7FFF_FFFF);
        idle_gap(1'b0);
        issue_request(CMD_ATTACH, 6'd63, 31'h7FFF_FFFF);
        issue_request(CMD_ATTACH, 6'd0, 31'h7FFF_FFFF);
        issue_request(CMD_ATTACH, 6'd0, 31'h0000_0001);
        for (int i = 0; i < 6; i++) begin
            issue_request(CMD_ATTACH, 6'd0, KEY_W'(i + 2));
            idle_gap(1'b0);
        end
        issue_request(CMD_ATTACH, 6'd0, 31'h5555_5555);
        for (int i = 0; i < 8; i++) begin
            issue_request(CMD_ATTACH, 6'd1, 31'h2AAA_AAA0 + KEY_W'(i));
        end
        issue_request(CMD_ATTACH, 6'd2, 31'h5555_5555);
        issue_request(CMD_DETACH, 6'd63, 31'h7FFF_FFFF);
        issue_request(CMD_DETACH, 6'd0, 31'h0000_0001);
        issue_request(CMD_DETACH, 6'd0, 31'h7FFF_FFFF);
        directed_count = sent;
        wait_drained();

        for (int i = 0; i < 20; i++) begin
            key_pool[i] = KEY_W'($urandom());
        end
        key_pool[0] = 31'h7FFF_FFFF;
        key_pool[1] = 31'h0000_0001;

        random_count = 0;
        phase = 0;
        while (random_count < RANDOM_ITEMS) begin
            attach_pct = (phase % 2 == 0) ? 25 : 75;
            quiet = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 100);
            for (int i = 0; i < 4; i++) begin
                hot_pid[i] = PID_W'($urandom_range(0, NUM_PROCS - 1));
            end
            key_pool[$urandom_range(2, 19)] = KEY_W'($urandom());
            for (int k = 0; k < phase_len && random_count < RANDOM_ITEMS; k++) begin
                pid = ($urandom_range(0, 99) < 80) ? hot_pid[$urandom_range(0, 3)]
                                                   : PID_W'($urandom_range(0, NUM_PROCS - 1));
                cmd = ($urandom_range(0, 99) < attach_pct) ? CMD_ATTACH : CMD_DETACH;
                roll = $urandom_range(0, 99);
                key = key_pool[$urandom_range(0, 19)];
                if (roll < 3) begin
                    key = '0;
                end else if (roll < 12) begin
                    key = KEY_W'($urandom());
                end else if (cmd == CMD_DETACH && roll >= 20) begin
                    first = $urandom_range(0, NUM_SLOTS - 1);
                    for (int j = 0; j < NUM_SLOTS; j++) begin
                        if (sb.proc_key[pid][(first + j) % NUM_SLOTS] != '0) begin
                            key = sb.proc_key[pid][(first + j) % NUM_SLOTS];
                            break;
                        end
                    end
                end
                issue_request(cmd, pid, key);
                random_count++;
                idle_gap(quiet);
            end
            if (phase % 2 == 1) wait_drained();
            phase++;
        end

        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("%0d transactions (%0d directed, %0d random in %0d phases), %0d results checked",
                 sent, directed_count, random_count, phase, sb.checked);
        $display("statuses seen: ok %0d, already held %0d, process full %0d, %s %0d, %s %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_HELD], sb.status_seen[ST_PROC_FULL],
                 "global full", sb.status_seen[ST_GLOB_FULL],
                 "not held", sb.status_seen[ST_NOT_HELD]);
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
